// ===== hdl/klbl_pkg.sv =====
// Package for the keyed leaky-bucket limiter.
// Holds sizes, request/result types, config indexes and reset values, and the bucket index wrap.
// No dependencies.
package klbl_pkg;

    localparam int NUM_BUCKETS = 16;
    localparam int FRAC_BITS   = 16;

    localparam int IDX_IN_W = 4;
    localparam int TIME_W   = 32;
    localparam int CAP_W    = 16;
    localparam int RATE_W   = 32;
    localparam int RETRY_W  = 16;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;

    localparam int BKT_W  = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
    // Level never exceeds the largest capacity in whole requests.
    localparam int LVL_W  = CAP_W + FRAC_BITS;
    localparam int CEIL_W = CAP_W + 1;
    localparam int PROD_W = TIME_W + RATE_W;

    localparam logic [LVL_W-1:0] ONE_REQ = LVL_W'(1) << FRAC_BITS;

    localparam logic [CAP_W-1:0]   CAPACITY_RST = CAP_W'(10);
    localparam logic [RATE_W-1:0]  LEAK_RST     = RATE_W'(66);
    localparam logic [RETRY_W-1:0] RETRY_RST    = RETRY_W'(2);

    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_LEAK_RATE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY     = CFG_IDX_W'(2);

    typedef struct packed {
        logic [IDX_IN_W-1:0] bucket_index;
        logic [TIME_W-1:0]   arrival_time;
    } t_req;

    typedef struct packed {
        logic               allowed;
        logic [CAP_W-1:0]   remaining;
        logic [RETRY_W-1:0] retry_after_ms;
    } t_res;

    // Request between the drain multiply and the decision.
    typedef struct packed {
        logic [BKT_W-1:0]  idx;
        logic [TIME_W-1:0] now;
        logic              fresh;
        logic [LVL_W-1:0]  drain_lo;
        logic              drain_ovf;
    } t_mid;

    typedef struct packed {
        t_res             res;
        logic [LVL_W-1:0] new_level;
    } t_dec;

    // Wrap a request index onto the bucket table by repeated subtract.
    function automatic logic [BKT_W-1:0] bkt_wrap(input logic [IDX_IN_W-1:0] idx_in);
        logic [IDX_IN_W-1:0] v;
        v = idx_in;
        for (int k = 0; k < 8; k++) begin
            if (32'(v) >= NUM_BUCKETS) begin
                v = v - IDX_IN_W'(NUM_BUCKETS);
            end
        end
        return BKT_W'(v);
    endfunction

endpackage

// ===== hdl/klbl_decide.sv =====
// Admission decision for one drained bucket.
// Floors the level at zero, takes its ceiling, compares against capacity.
// Depends on klbl_pkg.
module klbl_decide (
    input  logic [klbl_pkg::LVL_W-1:0]   i_level,
    input  logic [klbl_pkg::LVL_W-1:0]   i_drain_lo,
    input  logic                         i_drain_ovf,
    input  logic [klbl_pkg::CAP_W-1:0]   i_capacity,
    input  logic [klbl_pkg::RETRY_W-1:0] i_retry,
    output klbl_pkg::t_dec               o_dec
);

    logic                          w_empty;
    logic [klbl_pkg::LVL_W-1:0]    w_lvl;
    logic [klbl_pkg::LVL_W:0]      w_round;
    logic [klbl_pkg::CEIL_W-1:0]   w_ceil;
    logic [klbl_pkg::CEIL_W-1:0]   w_cap_ext;
    logic [klbl_pkg::CEIL_W-1:0]   w_left;
    logic                          w_admit;

    // Drain at or above the level empties the bucket.
    assign w_empty = i_drain_ovf || (i_drain_lo >= i_level);
    assign w_lvl   = w_empty ? '0 : (i_level - i_drain_lo);

    assign w_round   = {1'b0, w_lvl} + {1'b0, klbl_pkg::ONE_REQ - klbl_pkg::LVL_W'(1)};
    assign w_ceil    = klbl_pkg::CEIL_W'(w_round >> klbl_pkg::FRAC_BITS);
    assign w_cap_ext = {1'b0, i_capacity};
    assign w_admit   = w_ceil < w_cap_ext;
    // Adding one whole request raises the ceiling by exactly one.
    assign w_left    = w_cap_ext - w_ceil - klbl_pkg::CEIL_W'(1);

    always_comb begin
        o_dec.res.allowed        = w_admit;
        o_dec.res.remaining      = w_admit ? w_left[klbl_pkg::CAP_W-1:0] : '0;
        o_dec.res.retry_after_ms = w_admit ? '0 : i_retry;
        o_dec.new_level          = w_admit ? (w_lvl + klbl_pkg::ONE_REQ) : w_lvl;
    end

endmodule

// ===== hdl/keyed_leaky_bucket_limiter.sv =====
// Keyed leaky-bucket limiter, top level: per-bucket tables, drain multiply, decision.
// Accept to result passes input, drain and result registers; one request per cycle unless
// the result side stalls, a rate set by the bucket read-modify-write in the decision stage.
// Reset (synchronous, active low) clears all bucket valid marks and pipeline valids and
// loads capacity 10, leak rate 66, retry wait 2. Depends on klbl_pkg and klbl_decide.
module keyed_leaky_bucket_limiter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    output logic                            o_req_ready,
    input  klbl_pkg::t_req                  i_req,
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output klbl_pkg::t_res                  o_res,
    input  logic                            i_cfg_we,
    input  logic [klbl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [klbl_pkg::CFG_W-1:0]      i_cfg_data
);

    // Configuration registers.
    logic [klbl_pkg::CAP_W-1:0]   r_capacity;
    logic [klbl_pkg::RATE_W-1:0]  r_leak;
    logic [klbl_pkg::RETRY_W-1:0] r_retry;

    // Bucket tables. Level and time are only read once the valid mark is set.
    logic [klbl_pkg::NUM_BUCKETS-1:0] r_bkt_valid;
    logic [klbl_pkg::LVL_W-1:0]       r_level [klbl_pkg::NUM_BUCKETS];
    logic [klbl_pkg::TIME_W-1:0]      r_last  [klbl_pkg::NUM_BUCKETS];

    // Pipeline: input register, drain register, result register.
    logic                         r_in_v;
    logic [klbl_pkg::BKT_W-1:0]   r_in_idx;
    logic [klbl_pkg::TIME_W-1:0]  r_in_now;
    logic                         r_mid_v;
    klbl_pkg::t_mid               r_mid;
    klbl_pkg::t_mid               n_mid;
    logic                         r_out_v;
    klbl_pkg::t_res               r_out;

    logic                         w_out_free;
    logic                         w_mid_go;
    logic                         w_mid_free;
    logic                         w_in_go;
    logic                         w_in_free;
    logic                         w_req_go;

    logic                         w_fwd;
    logic                         w_seen;
    logic [klbl_pkg::TIME_W-1:0]  w_last;
    logic [klbl_pkg::TIME_W-1:0]  w_elapsed;
    logic [klbl_pkg::PROD_W-1:0]  w_prod;
    logic [klbl_pkg::LVL_W-1:0]   w_lvl_old;
    klbl_pkg::t_dec               w_dec;

    // Handshake: each stage advances when the stage after it is free or draining.
    assign w_out_free  = !r_out_v || i_res_ready;
    assign w_mid_go    = r_mid_v && w_out_free;
    assign w_mid_free  = !r_mid_v || w_mid_go;
    assign w_in_go     = r_in_v && w_mid_free;
    assign w_in_free   = !r_in_v || w_in_go;
    assign w_req_go    = i_req_valid && w_in_free;

    assign o_req_ready = w_in_free;
    assign o_res_valid = r_out_v;
    assign o_res       = r_out;

    // Drain stage. The request ahead in the decision stage has not written the
    // tables yet, so forward its time and valid mark when it hits the same bucket.
    assign w_fwd     = r_mid_v && (r_mid.idx == r_in_idx);
    assign w_seen    = w_fwd || r_bkt_valid[r_in_idx];
    assign w_last    = w_fwd ? r_mid.now : r_last[r_in_idx];
    // A new bucket starts at the arrival time, so nothing drains.
    assign w_elapsed = w_seen ? (r_in_now - w_last) : '0;
    assign w_prod    = klbl_pkg::PROD_W'(w_elapsed) * klbl_pkg::PROD_W'(r_leak);

    always_comb begin
        n_mid.idx       = r_in_idx;
        n_mid.now       = r_in_now;
        n_mid.fresh     = !w_seen;
        n_mid.drain_lo  = w_prod[klbl_pkg::LVL_W-1:0];
        n_mid.drain_ovf = |w_prod[klbl_pkg::PROD_W-1:klbl_pkg::LVL_W];
    end

    // Decision stage: a new bucket reads as empty.
    assign w_lvl_old = r_mid.fresh ? '0 : r_level[r_mid.idx];

    klbl_decide u_decide (
        .i_level     (w_lvl_old),
        .i_drain_lo  (r_mid.drain_lo),
        .i_drain_ovf (r_mid.drain_ovf),
        .i_capacity  (r_capacity),
        .i_retry     (r_retry),
        .o_dec       (w_dec)
    );

    // Configuration writes; indexes beyond the list are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= klbl_pkg::CAPACITY_RST;
            r_leak     <= klbl_pkg::LEAK_RST;
            r_retry    <= klbl_pkg::RETRY_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                klbl_pkg::CFG_CAPACITY:  r_capacity <= i_cfg_data[klbl_pkg::CAP_W-1:0];
                klbl_pkg::CFG_LEAK_RATE: r_leak     <= i_cfg_data[klbl_pkg::RATE_W-1:0];
                klbl_pkg::CFG_RETRY:     r_retry    <= i_cfg_data[klbl_pkg::RETRY_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Pipeline valids and bucket valid marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v      <= 1'b0;
            r_mid_v     <= 1'b0;
            r_out_v     <= 1'b0;
            r_bkt_valid <= '0;
        end else begin
            if (w_in_free) begin
                r_in_v <= i_req_valid;
            end
            if (w_mid_free) begin
                r_mid_v <= w_in_go;
            end
            if (w_out_free) begin
                r_out_v <= w_mid_go;
            end
            if (w_mid_go) begin
                r_bkt_valid[r_mid.idx] <= 1'b1;
            end
        end
    end

    // Payload registers and table writes; refused requests still store the drain.
    always_ff @(posedge i_clk) begin
        if (w_req_go) begin
            r_in_idx <= klbl_pkg::bkt_wrap(i_req.bucket_index);
            r_in_now <= i_req.arrival_time;
        end
        if (w_in_go) begin
            r_mid <= n_mid;
        end
        if (w_mid_go) begin
            r_out                <= w_dec.res;
            r_level[r_mid.idx]   <= w_dec.new_level;
            r_last[r_mid.idx]    <= r_mid.now;
        end
    end

`ifndef SYNTHESIS
    // A bucket decided on is marked valid from then on.
    a_mark_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_go |=> r_bkt_valid[$past(r_mid.idx)])
        else $error("bucket valid mark not set after decision");

    // A new bucket with nonzero capacity always admits its first request.
    a_fresh_admit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mid_go && r_mid.fresh && (r_capacity != '0)) |=> o_res.allowed)
        else $error("first request to a new bucket refused");

    // A refusal never raises the stored level.
    a_refuse_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_mid_go && !w_dec.res.allowed) |=>
            (r_level[$past(r_mid.idx)] <= $past(w_lvl_old)))
        else $error("level rose on refused request");

    // Input stalls only behind a held request.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_req_ready |-> (r_in_v && r_mid_v && r_out_v && !i_res_ready))
        else $error("request port stalled with room in the pipeline");
`endif

endmodule

// ===== dv/klbl_verdict_checker.sv =====
`timescale 1ns / 100ps
// Verdict checker for the keyed leaky-bucket limiter: watches the request, result
// and register write ports, predicts each admit/refuse verdict and compares.
// Depends on klbl_pkg.
module klbl_verdict_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_req_valid,
    input  logic                            i_req_ready,
    input  klbl_pkg::t_req                  i_req,
    input  logic                            i_res_valid,
    input  logic                            i_res_ready,
    input  klbl_pkg::t_res                  i_res,
    input  logic                            i_cfg_we,
    input  logic [klbl_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [klbl_pkg::CFG_W-1:0]      i_cfg_data,
    output int                              o_fail_count,
    output int                              o_pending
);

    localparam logic [63:0] WHOLE_REQ = 64'(1) << klbl_pkg::FRAC_BITS;

    logic [klbl_pkg::CAP_W-1:0]   capacity_q;
    logic [klbl_pkg::RATE_W-1:0]  leak_q;
    logic [klbl_pkg::RETRY_W-1:0] retry_q;

    logic                         bucket_seen  [klbl_pkg::NUM_BUCKETS];
    logic [63:0]                  bucket_fill  [klbl_pkg::NUM_BUCKETS];
    logic [klbl_pkg::TIME_W-1:0]  bucket_stamp [klbl_pkg::NUM_BUCKETS];

    klbl_pkg::t_res expected_verdicts [$];
    klbl_pkg::t_res want;
    int             fails = 0;

    assign o_fail_count = fails;

    // Round a fixed-point fill level up to whole requests.
    function automatic logic [63:0] whole_requests(input logic [63:0] fill);
        return (fill + WHOLE_REQ - 64'(1)) >> klbl_pkg::FRAC_BITS;
    endfunction

    // Drain the bucket to the arrival time, then admit or refuse.
    function automatic klbl_pkg::t_res admit_request(input klbl_pkg::t_req r);
        int                          b;
        logic [klbl_pkg::TIME_W-1:0] elapsed;
        logic [63:0]                 drain;
        logic [63:0]                 fill;
        klbl_pkg::t_res              v;
        b = int'(r.bucket_index) % klbl_pkg::NUM_BUCKETS;
        if (!bucket_seen[b]) begin
            bucket_seen[b]  = 1'b1;
            bucket_fill[b]  = '0;
            bucket_stamp[b] = r.arrival_time;
        end
        elapsed = r.arrival_time - bucket_stamp[b];
        drain   = 64'(elapsed) * 64'(leak_q);
        fill    = bucket_fill[b];
        fill    = (drain >= fill) ? 64'(0) : fill - drain;
        bucket_stamp[b] = r.arrival_time;
        v = '0;
        if (whole_requests(fill) < 64'(capacity_q)) begin
            fill        = fill + WHOLE_REQ;
            v.allowed   = 1'b1;
            v.remaining = klbl_pkg::CAP_W'(64'(capacity_q) - whole_requests(fill));
        end else begin
            v.retry_after_ms = retry_q;
        end
        bucket_fill[b] = fill;
        return v;
    endfunction

    function automatic void check_field(input string what, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val) begin
            fails++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_val, act_val);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            capacity_q = klbl_pkg::CAPACITY_RST;
            leak_q     = klbl_pkg::LEAK_RST;
            retry_q    = klbl_pkg::RETRY_RST;
            foreach (bucket_seen[k]) begin
                bucket_seen[k] = 1'b0;
            end
            expected_verdicts.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    klbl_pkg::CFG_CAPACITY:  capacity_q = i_cfg_data[klbl_pkg::CAP_W-1:0];
                    klbl_pkg::CFG_LEAK_RATE: leak_q     = i_cfg_data[klbl_pkg::RATE_W-1:0];
                    klbl_pkg::CFG_RETRY:     retry_q    = i_cfg_data[klbl_pkg::RETRY_W-1:0];
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                expected_verdicts.push_back(admit_request(i_req));
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_verdicts.size() == 0) begin
                    fails++;
                    $display("%0t ns: result mismatch, expected none, actual %0d/%0d/%0d",
                             $time, i_res.allowed, i_res.remaining, i_res.retry_after_ms);
                end else begin
                    want = expected_verdicts.pop_front();
                    check_field("allowed", want.allowed, i_res.allowed);
                    check_field("remaining", want.remaining, i_res.remaining);
                    check_field("retry_after_ms", want.retry_after_ms, i_res.retry_after_ms);
                end
            end
        end
        o_pending <= expected_verdicts.size();
    end

endmodule

// ===== dv/keyed_leaky_bucket_limiter_test.sv =====
`timescale 1ns / 100ps
// Testbench top for the keyed leaky-bucket limiter: drives requests and register
// writes, stalls the result side, and reports the verdict of klbl_verdict_checker.
// Depends on klbl_pkg, keyed_leaky_bucket_limiter and klbl_verdict_checker.
module keyed_leaky_bucket_limiter_test;

    localparam int CYCLE_LIMIT     = 400000;
    // Extra settle time after the last verdict, before touching registers or ending.
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_REQUESTS = 500;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    klbl_pkg::t_req                  req = '0;
    logic                            res_valid;
    logic                            res_ready = 1'b0;
    klbl_pkg::t_res                  res;
    logic                            cfg_we = 1'b0;
    logic [klbl_pkg::CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [klbl_pkg::CFG_W-1:0]      cfg_data = '0;

    int fail_count;
    int pending;
    int cycle_count = 0;

    // Result-side stall pattern, retuned per phase.
    int stall_pct = 0;
    int stall_max = 1;
    int stall_left = 0;

    // Request pacing and arrival-time generation.
    int                          gap_max = 0;
    int                          burst_left = 0;
    int                          sent = 0;
    int                          phase_len;
    int                          hot_base = 0;
    logic [klbl_pkg::TIME_W-1:0] tick_now = '0;
    logic [klbl_pkg::IDX_IN_W-1:0] pick_bucket;
    logic [klbl_pkg::TIME_W-1:0] pick_time;
    logic [31:0]                 cap_word;
    logic [31:0]                 leak_word;
    logic [31:0]                 retry_word;

    keyed_leaky_bucket_limiter dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    klbl_verdict_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_req_valid  (req_valid),
        .i_req_ready  (req_ready),
        .i_req        (req),
        .i_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .i_res        (res),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Receiver: stay ready, or drop ready for a random stretch at a per-phase rate.
    always @(posedge clk) begin
        if (stall_left > 0) begin
            res_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
            res_ready <= 1'b0;
            stall_left = $urandom_range(0, stall_max - 1);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Offer one request and hold it until the block takes it.
    task automatic offer(input logic [klbl_pkg::IDX_IN_W-1:0] bucket,
                         input logic [klbl_pkg::TIME_W-1:0] arrival);
        req_valid          <= 1'b1;
        req.bucket_index   <= bucket;
        req.arrival_time   <= arrival;
        do @(posedge clk); while (!req_ready);
    endtask

    // Drop valid and wait until every predicted verdict has come back.
    task automatic settle();
        req_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write all three limits back to back; optionally poke the unused index too.
    task automatic program_limits(input logic [31:0] cap_w, input logic [31:0] leak_w,
                                  input logic [31:0] retry_w, input bit poke_unused);
        cfg_we   <= 1'b1;
        cfg_idx  <= klbl_pkg::CFG_CAPACITY;
        cfg_data <= cap_w;
        @(posedge clk);
        cfg_idx  <= klbl_pkg::CFG_LEAK_RATE;
        cfg_data <= leak_w;
        @(posedge clk);
        cfg_idx  <= klbl_pkg::CFG_RETRY;
        cfg_data <= retry_w;
        @(posedge clk);
        if (poke_unused) begin
            // Index past the register list must be ignored.
            cfg_idx  <= klbl_pkg::CFG_IDX_W'(3);
            cfg_data <= $urandom;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset limits (capacity 10, leak 66, retry 2).
        stall_pct = 30;
        stall_max = 4;
        // Fill bucket 0 with no elapsed time: ten admits, then a refusal.
        repeat (11) offer(4'd0, 32'd0);
        // New bucket at the top of the tick range, then an arrival after the wrap.
        offer(4'd15, 32'hFFFF_FFFF);
        offer(4'd15, 32'h0000_0400);
        // Partial drain leaves a fractional level that rounds up to one short of full.
        offer(4'd0, 32'd1000);
        // Drain far past the level: floor at zero.
        offer(4'd0, 32'h8000_0000);
        offer(4'd7, 32'h5555_5555);
        offer(4'd8, 32'hAAAA_AAAA);

        // Capacity zero (junk in the upper data bits), no leak, widest retry.
        settle();
        program_limits(32'hABCD_0000, 32'd0, 32'h0000_FFFF, 1'b1);
        offer(4'd3, 32'd10);
        offer(4'd3, 32'd20);

        // Widest capacity and leak, zero retry: any elapsed tick empties the bucket.
        settle();
        program_limits(32'h0000_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0);
        offer(4'd3, 32'd21);
        offer(4'd3, 32'd21);
        offer(4'd4, 32'd0);
        offer(4'd3, 32'd22);

        // Random phases, each with its own limits and idling pattern.
        while (sent < RANDOM_REQUESTS) begin
            settle();
            case ($urandom_range(0, 7))
                0:       cap_word = 32'd1;
                1:       cap_word = 32'd2;
                2:       cap_word = 32'd3;
                3:       cap_word = 32'd10;
                4:       cap_word = 32'd65535;
                5:       cap_word = 32'd0;
                default: cap_word = $urandom_range(1, 20);
            endcase
            cap_word[31:16] = 16'($urandom);
            case ($urandom_range(0, 7))
                0:       leak_word = 32'd0;
                1:       leak_word = 32'd66;
                2:       leak_word = $urandom_range(1, 200);
                3:       leak_word = 32'hFFFF_FFFF;
                4:       leak_word = 32'd65536;
                5:       leak_word = $urandom;
                default: leak_word = $urandom_range(20, 2000);
            endcase
            case ($urandom_range(0, 3))
                0:       retry_word = 32'd0;
                1:       retry_word = 32'h0000_FFFF;
                default: retry_word = $urandom;
            endcase
            program_limits(cap_word, leak_word, retry_word, $urandom_range(0, 3) == 0);

            case ($urandom_range(0, 2))
                0:       gap_max = 0;
                1:       gap_max = 3;
                default: gap_max = 12;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 20;
                default: stall_pct = 50;
            endcase
            stall_max  = $urandom_range(1, 8);
            hot_base   = $urandom_range(0, 12);
            burst_left = $urandom_range(1, 16);
            phase_len  = $urandom_range(30, 70);

            repeat (phase_len) begin
                // Most requests hammer a few hot buckets on a steadily advancing clock;
                // the rest hit any bucket or jump to an arbitrary time.
                if ($urandom_range(0, 3) != 0) begin
                    pick_bucket = klbl_pkg::IDX_IN_W'(hot_base + $urandom_range(0, 3));
                end else begin
                    pick_bucket = klbl_pkg::IDX_IN_W'($urandom);
                end
                case ($urandom_range(0, 19))
                    0:       tick_now = $urandom;
                    1:       tick_now = tick_now + $urandom_range(0, 3000);
                    2, 3, 4: tick_now = tick_now + $urandom_range(0, 3000);
                    default: tick_now = tick_now + $urandom_range(0, 40);
                endcase
                pick_time = ($urandom_range(0, 19) == 0) ? 32'($urandom) : tick_now;

                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    if (gap_max != 0) begin
                        req_valid <= 1'b0;
                        repeat ($urandom_range(1, gap_max)) @(posedge clk);
                    end
                end
                burst_left = burst_left - 1;
                offer(pick_bucket, pick_time);
                sent = sent + 1;
            end
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/klbl_pkg.sv
hdl/klbl_decide.sv
hdl/keyed_leaky_bucket_limiter.sv
dv/klbl_verdict_checker.sv
dv/keyed_leaky_bucket_limiter_test.sv
